// ===== rtl/iff_pkg.sv =====
// Shared types, constants and helpers for the image flood fill block.
// Used by iff_ctrl and image_flood_fill_core; depends on nothing else.
package iff_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int PIXEL_BITS = 16;

  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int VAL_W     = 16;
  localparam int CMD_W     = 2;
  localparam int SIZE_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam int CELLS   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int DEPTH_W = ADDR_W + 1;

  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_WRITE = 2'd0;
  localparam cmd_t CMD_FILL  = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ROWS = 1'b0;
  localparam cfg_idx_t CFG_COLS = 1'b1;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  typedef struct packed {
    cmd_t             command;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] col_index;
    logic [VAL_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } coord_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    pixel_t wdata;
    addr_t  raddr;
  } img_req_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    logic  wdata;
    addr_t raddr;
  } vis_req_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    coord_t wdata;
    addr_t  raddr;
  } stk_req_t;

  function automatic addr_t cell_addr(coord_t c);
    int unsigned a;
    a = int'(c.row) * MAX_COLS + int'(c.col);
    return a[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/iff_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; has no package dependencies.
module iff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/iff_ctrl.sv =====
// Command sequencer and flood fill walker for the image flood fill block.
// Depends on iff_pkg; drives the image, visited and stack RAMs in the top level.
module iff_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  iff_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output iff_pkg::out_item_t out_data,
  input  logic [iff_pkg::SIZE_W-1:0] rows_in_use,
  input  logic [iff_pkg::SIZE_W-1:0] cols_in_use,
  output iff_pkg::img_req_t img_req,
  input  iff_pkg::pixel_t   img_rdata,
  output iff_pkg::vis_req_t vis_req,
  input  logic              vis_rdata,
  output iff_pkg::stk_req_t stk_req,
  input  iff_pkg::coord_t   stk_rdata
);
  import iff_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CMD, S_CLEAR, S_START, S_POP, S_POPW, S_NB, S_NBCHK, S_DONE
  } state_t;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  state_t               state_r;
  cmd_t                 cmd_r;
  coord_t               pos_r;
  pixel_t               val_r;
  pixel_t               before_r;
  pixel_t               old_r;
  logic                 oor_r;
  addr_t                clr_r;
  logic [DEPTH_W-1:0]   depth_r;
  coord_t               cur_r;
  coord_t               nb_r;
  logic [1:0]           dir_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic                 accept;
  logic                 in_range;
  coord_t               nb;
  logic                 nb_ok;
  logic                 push_hit;
  logic [SIZE_W-1:0]    row_ext;
  logic [SIZE_W-1:0]    col_ext;
  logic [SIZE_W-1:0]    rows_lim;
  logic [SIZE_W-1:0]    cols_lim;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign in_range = ({1'b0, in_data.row_index} < rows_in_use) &&
                    ({1'b0, in_data.col_index} < cols_in_use);

  assign rows_lim = (rows_in_use > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_in_use;
  assign cols_lim = (cols_in_use > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_in_use;

  assign row_ext = {1'b0, cur_r.row};
  assign col_ext = {1'b0, cur_r.col};

  always_comb begin
    nb    = cur_r;
    nb_ok = 1'b0;
    unique case (dir_r)
      DIR_RIGHT: begin
        nb.col = cur_r.col + 1'b1;
        nb_ok  = (col_ext + 1'b1) < cols_lim;
      end
      DIR_LEFT: begin
        nb.col = cur_r.col - 1'b1;
        nb_ok  = (cur_r.col != '0);
      end
      DIR_DOWN: begin
        nb.row = cur_r.row + 1'b1;
        nb_ok  = (row_ext + 1'b1) < rows_lim;
      end
      DIR_UP: begin
        nb.row = cur_r.row - 1'b1;
        nb_ok  = (cur_r.row != '0);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign push_hit = !vis_rdata && (img_rdata == old_r);

  always_comb begin
    img_req       = '0;
    vis_req       = '0;
    stk_req       = '0;
    img_req.raddr = (state_r == S_NB) ? cell_addr(nb) : cell_addr(pos_r);
    vis_req.raddr = cell_addr(nb);
    stk_req.raddr = depth_r[ADDR_W-1:0] - 1'b1;
    unique case (state_r)
      S_CMD: begin
        img_req.we    = (cmd_r == CMD_WRITE);
        img_req.waddr = cell_addr(pos_r);
        img_req.wdata = val_r;
      end
      S_CLEAR: begin
        vis_req.we    = 1'b1;
        vis_req.waddr = clr_r;
        vis_req.wdata = 1'b0;
      end
      S_START: begin
        vis_req.we    = 1'b1;
        vis_req.waddr = cell_addr(pos_r);
        vis_req.wdata = 1'b1;
        stk_req.we    = 1'b1;
        stk_req.waddr = '0;
        stk_req.wdata = pos_r;
      end
      S_POPW: begin
        img_req.we    = 1'b1;
        img_req.waddr = cell_addr(stk_rdata);
        img_req.wdata = val_r;
      end
      S_NBCHK: begin
        vis_req.we    = push_hit;
        vis_req.waddr = cell_addr(nb_r);
        vis_req.wdata = 1'b1;
        stk_req.we    = push_hit && (depth_r < DEPTH_W'(CELLS));
        stk_req.waddr = depth_r[ADDR_W-1:0];
        stk_req.wdata = nb_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
      dir_r       <= DIR_RIGHT;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r     <= in_data.command;
            pos_r.row <= in_data.row_index;
            pos_r.col <= in_data.col_index;
            val_r     <= PIXEL_BITS'(in_data.pixel_value);
            oor_r     <= !in_range;
            before_r  <= '0;
            state_r   <= in_range ? S_READ : S_DONE;
          end
        end
        S_READ: begin
          state_r <= S_CMD;
        end
        S_CMD: begin
          before_r <= img_rdata;
          old_r    <= img_rdata;
          clr_r    <= '0;
          state_r  <= (cmd_r == CMD_FILL) ? S_CLEAR : S_DONE;
        end
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == ADDR_W'(CELLS - 1)) begin
            state_r <= S_START;
          end
        end
        S_START: begin
          depth_r <= DEPTH_W'(1);
          state_r <= S_POP;
        end
        S_POP: begin
          if (depth_r == '0) begin
            state_r <= S_DONE;
          end else begin
            depth_r <= depth_r - 1'b1;
            state_r <= S_POPW;
          end
        end
        S_POPW: begin
          cur_r   <= stk_rdata;
          dir_r   <= DIR_RIGHT;
          state_r <= S_NB;
        end
        S_NB: begin
          if (nb_ok) begin
            nb_r    <= nb;
            state_r <= S_NBCHK;
          end else begin
            dir_r <= dir_r + 1'b1;
            if (dir_r == DIR_UP) begin
              state_r <= S_POP;
            end
          end
        end
        S_NBCHK: begin
          if (push_hit && (depth_r < DEPTH_W'(CELLS))) begin
            depth_r <= depth_r + 1'b1;
          end
          dir_r   <= dir_r + 1'b1;
          state_r <= (dir_r == DIR_UP) ? S_POP : S_NB;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_item_r.read_value   <= VAL_W'(before_r);
            out_item_r.out_of_range <= oor_r;
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/image_flood_fill_core.sv =====
// Top level of the image flood fill block: size registers, the three RAMs
// and the sequencer. Depends on iff_pkg, iff_ram and iff_ctrl.
//
// Each input transaction carries one command: write a pixel, read a pixel,
// or flood fill from a start pixel with a new color. Each command returns
// exactly one output transaction with the pixel value at its coordinate as
// it was before the command, or out_of_range set when the coordinate lies
// outside the size held in the rows and columns registers.
// The block works on one command at a time. A read or a write passes
// through S_READ and S_CMD to S_DONE, where its result is registered; an
// out-of-range command goes straight to S_DONE. The next command is taken
// once the sequencer is back in S_IDLE. A fill first clears all 4096
// entries of the visited RAM, one entry per cycle, then pops each pixel
// from the stack (S_POP, S_POPW) and checks its four neighbors in S_NB
// and S_NBCHK through the registered RAM reads.
// A result waits in an output register while the receiver stalls; the next
// command is taken meanwhile and its result is held back until that
// register is free. After reset the sizes are 64 by 64 and the image is
// undefined until written.
module image_flood_fill_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  iff_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output iff_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [iff_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iff_pkg::SIZE_W-1:0]    cfg_data
);
  import iff_pkg::*;

  logic [SIZE_W-1:0] rows_r;
  logic [SIZE_W-1:0] cols_r;

  img_req_t img_req;
  vis_req_t vis_req;
  stk_req_t stk_req;
  pixel_t   img_rdata;
  logic     vis_rdata;
  coord_t   stk_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SIZE_W'(MAX_ROWS);
      cols_r <= SIZE_W'(MAX_COLS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS: rows_r <= cfg_data;
        CFG_COLS: cols_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  iff_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .rows_in_use (rows_r),
    .cols_in_use (cols_r),
    .img_req     (img_req),
    .img_rdata   (img_rdata),
    .vis_req     (vis_req),
    .vis_rdata   (vis_rdata),
    .stk_req     (stk_req),
    .stk_rdata   (stk_rdata)
  );

  iff_ram #(.WIDTH(PIXEL_BITS), .DEPTH(CELLS)) u_image_ram (
    .clk   (clk),
    .we    (img_req.we),
    .waddr (img_req.waddr),
    .wdata (img_req.wdata),
    .raddr (img_req.raddr),
    .rdata (img_rdata)
  );

  iff_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited_ram (
    .clk   (clk),
    .we    (vis_req.we),
    .waddr (vis_req.waddr),
    .wdata (vis_req.wdata),
    .raddr (vis_req.raddr),
    .rdata (vis_rdata)
  );

  iff_ram #(.WIDTH($bits(coord_t)), .DEPTH(CELLS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_req.we),
    .waddr (stk_req.waddr),
    .wdata (stk_req.wdata),
    .raddr (stk_req.raddr),
    .rdata (stk_rdata)
  );

endmodule
